// ----- rtl/core/spta_pkg.sv -----
// Shared types and constants for the sparse polynomial term adder.
// Holds term layout, per-cell command codes and result status codes.
// No dependencies.
`default_nettype none

package spta_pkg;

  localparam int COEF_W = 16;
  localparam int EXPO_W = 8;
  localparam int STAT_W = 3;
  localparam int CMD_W  = 3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_EMIT         = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERT       = 3'd1;
  localparam logic [STAT_W-1:0] ST_COMBINE      = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_REMOVED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY        = 3'd5;

  // Commands broadcast to every cell of the chain
  localparam logic [CMD_W-1:0] CELL_HOLD = 3'd0;
  localparam logic [CMD_W-1:0] CELL_CMP  = 3'd1;
  localparam logic [CMD_W-1:0] CELL_INS  = 3'd2;
  localparam logic [CMD_W-1:0] CELL_DEL  = 3'd3;
  localparam logic [CMD_W-1:0] CELL_WR   = 3'd4;
  localparam logic [CMD_W-1:0] CELL_SHL  = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [EXPO_W-1:0] expo;
  } term_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [EXPO_W-1:0] key;
    logic [COEF_W-1:0] coef;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/spta_cell.sv -----
// One slot of the sorted term chain: holds a term, compares it against a
// broadcast exponent and moves terms to or from its neighbors.
// Depends on spta_pkg.
`default_nettype none

module spta_cell (
  input  wire logic              clk,
  input  wire spta_pkg::cell_cmd_t cmd,
  input  wire logic              occ,        // slot lies below the fill count
  input  wire spta_pkg::term_t   prev_term,  // term of the slot above
  input  wire logic              prev_gt,    // slot above holds a larger exponent
  input  wire spta_pkg::term_t   next_term,  // term of the slot below
  output spta_pkg::term_t        term,
  output logic                   gt,         // registered: exponent above key
  output logic                   eq_now,     // live: exponent equals key
  output logic                   eq          // registered: exponent equals key
);

  spta_pkg::term_t term_r;
  logic            gt_r;
  logic            eq_r;

  assign term   = term_r;
  assign gt     = gt_r;
  assign eq     = eq_r;
  assign eq_now = occ && (term_r.expo == cmd.key);

  // Capture compare flags for the following update cycle
  always_ff @(posedge clk) begin
    if (cmd.op == spta_pkg::CELL_CMP) begin
      gt_r <= occ && (term_r.expo > cmd.key);
      eq_r <= occ && (term_r.expo == cmd.key);
    end
  end

  // Move or rewrite the held term
  always_ff @(posedge clk) begin
    case (cmd.op)
      spta_pkg::CELL_INS: begin
        if (!gt_r) begin
          if (prev_gt) begin
            term_r.coef <= cmd.coef;
            term_r.expo <= cmd.key;
          end else begin
            term_r <= prev_term;
          end
        end
      end
      spta_pkg::CELL_DEL: begin
        if (!gt_r) begin
          term_r <= next_term;
        end
      end
      spta_pkg::CELL_WR: begin
        if (eq_r) begin
          term_r.coef <= cmd.coef;
        end
      end
      spta_pkg::CELL_SHL: begin
        term_r <= next_term;
      end
      default: begin
        term_r <= term_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/sparse_polynomial_term_adder_unit.sv -----
// Top level of the sparse polynomial term adder: stream ports, control
// sequencer, output register and the chain of term cells.
// Depends on spta_pkg and spta_cell.
//
// Usage: the input stream carries one request per transaction. in_tuser
// selects add (0) or drain (1); in_tdata holds the term. An add yields one
// result transaction; a drain yields one transaction per stored term,
// highest exponent first, with tlast on the final one, and empties the
// table (an empty table yields a single empty-readout transaction).
// An add passes a compare step, then an update step that loads its result
// into the output register; a new add is taken in the cycle its result is
// loaded. A drain emits one term per cycle while the output register can
// be refilled, the chain shifting toward slot 0. The output register holds
// a result while out_tready is low; the sequencer then waits in its update
// or drain step, and in_tready stays low until that register can be refilled.
// cfg_wr_en writes the zero-removal flag; write it only while idle.
// Reset empties the table and sets zero removal on.
`default_nettype none

module sparse_polynomial_term_adder_unit #(
  parameter int TERM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,  // drop_zero_sums
  // Request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,     // [15:0] coef_in, [23:16] expo_in
  input  wire logic        in_tuser,     // [0] req_type
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [15:0] coef_out, [23:16] expo_out,
                                         // [28:24] term_count, rest zero
  output logic [3:0]       out_tuser,    // [2:0] status, [3] saturated
  output logic             out_tlast     // last_term
);

  localparam int CNT_W = $clog2(TERM_SLOTS + 1);
  localparam int CW    = spta_pkg::COEF_W;
  localparam int EW    = spta_pkg::EXPO_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r;
  logic [CW-1:0]    op_coef_r;
  logic [EW-1:0]    op_expo_r;
  logic [CW-1:0]    sum_r;
  logic             sat_r;
  logic             hit_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [spta_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [CW-1:0]         out_coef_r, out_coef_nxt;
  logic [EW-1:0]         out_expo_r, out_expo_nxt;
  logic                  out_sat_r, out_sat_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  spta_pkg::cell_cmd_t cmd;
  spta_pkg::term_t     cell_term [TERM_SLOTS];
  logic [TERM_SLOTS-1:0] cell_gt;
  logic [TERM_SLOTS-1:0] cell_eq_now;
  logic [TERM_SLOTS-1:0] cell_eq;
  logic [TERM_SLOTS-1:0] cell_occ;

  logic          out_free;
  logic          accept;
  logic          full;
  logic [CW-1:0] hit_coef;
  logic [CW:0]   sum_wide;
  logic [CW-1:0] sum_sat;
  logic          sum_ovf;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(TERM_SLOTS));

  // Cell chain
  for (genvar i = 0; i < TERM_SLOTS; i++) begin : g_cell
    spta_pkg::term_t prev_t;
    spta_pkg::term_t next_t;
    logic            prev_g;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_t = '0;
      assign prev_g = 1'b1;
    end else begin : g_body
      assign prev_t = cell_term[i-1];
      assign prev_g = cell_gt[i-1];
    end

    if (i == TERM_SLOTS - 1) begin : g_tail
      assign next_t = '0;
    end else begin : g_inner
      assign next_t = cell_term[i+1];
    end

    spta_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (cell_occ[i]),
      .prev_term (prev_t),
      .prev_gt   (prev_g),
      .next_term (next_t),
      .term      (cell_term[i]),
      .gt        (cell_gt[i]),
      .eq_now    (cell_eq_now[i]),
      .eq        (cell_eq[i])
    );
  end

  // Pick the coefficient of the matching slot (at most one matches)
  always_comb begin
    hit_coef = '0;
    for (int i = 0; i < TERM_SLOTS; i++) begin
      hit_coef = hit_coef | (cell_eq_now[i] ? cell_term[i].coef : '0);
    end
  end

  // Saturating sum of stored and incoming coefficient
  assign sum_wide = {hit_coef[CW-1], hit_coef} + {op_coef_r[CW-1], op_coef_r};
  assign sum_ovf  = sum_wide[CW] != sum_wide[CW-1];
  assign sum_sat  = sum_ovf ? {sum_wide[CW], {(CW-1){!sum_wide[CW]}}}
                            : sum_wide[CW-1:0];

  // Sequencer, cell commands and output register loading
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd.op         = spta_pkg::CELL_HOLD;
    cmd.key        = op_expo_r;
    cmd.coef       = op_coef_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_coef_nxt   = out_coef_r;
    out_expo_nxt   = out_expo_r;
    out_sat_nxt    = out_sat_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_tuser ? S_DRAIN : S_CMP;
        end
      end
      S_CMP: begin
        cmd.op    = spta_pkg::CELL_CMP;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_expo_nxt  = op_expo_r;
          out_last_nxt  = 1'b1;
          out_sat_nxt   = 1'b0;
          if (hit_r && (sum_r == '0) && drop_r) begin
            cmd.op         = spta_pkg::CELL_DEL;
            count_nxt      = count_r - 1'b1;
            out_status_nxt = spta_pkg::ST_ZERO_REMOVED;
            out_coef_nxt   = '0;
            out_sat_nxt    = sat_r;
            out_count_nxt  = count_r - 1'b1;
          end else if (hit_r) begin
            cmd.op         = spta_pkg::CELL_WR;
            cmd.coef       = sum_r;
            out_status_nxt = spta_pkg::ST_COMBINE;
            out_coef_nxt   = sum_r;
            out_sat_nxt    = sat_r;
            out_count_nxt  = count_r;
          end else if (full) begin
            out_status_nxt = spta_pkg::ST_FULL;
            out_coef_nxt   = op_coef_r;
            out_count_nxt  = count_r;
          end else begin
            cmd.op         = spta_pkg::CELL_INS;
            count_nxt      = count_r + 1'b1;
            out_status_nxt = spta_pkg::ST_INSERT;
            out_coef_nxt   = op_coef_r;
            out_count_nxt  = count_r + 1'b1;
          end
          if (accept) begin
            state_nxt = in_tuser ? S_DRAIN : S_CMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sat_nxt   = 1'b0;
          out_count_nxt = '0;
          if (count_r == '0) begin
            out_status_nxt = spta_pkg::ST_EMPTY;
            out_coef_nxt   = '0;
            out_expo_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.op         = spta_pkg::CELL_SHL;
            count_nxt      = count_r - 1'b1;
            out_status_nxt = spta_pkg::ST_EMIT;
            out_coef_nxt   = cell_term[0].coef;
            out_expo_nxt   = cell_term[0].expo;
            out_last_nxt   = (count_r == CNT_W'(1));
            if (count_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      drop_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        drop_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_coef_r <= in_tdata[CW-1:0];
      op_expo_r <= in_tdata[CW+EW-1:CW];
    end
    if (state_r == S_CMP) begin
      sum_r <= sum_sat;
      sat_r <= sum_ovf;
      hit_r <= |cell_eq_now;
    end
    out_status_r <= out_status_nxt;
    out_coef_r   <= out_coef_nxt;
    out_expo_r   <= out_expo_nxt;
    out_sat_r    <= out_sat_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, 5'(out_count_r), out_expo_r, out_coef_r};
  assign out_tuser  = {out_sat_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // Fill count never passes the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TERM_SLOTS))
    else $error("term count exceeds slot count");

  // At most one stored term matches the exponent being added
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(cell_eq))
    else $error("several slots share one exponent");

  // Only a drain produces results that are not the last of their request
  a_multi_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == spta_pkg::ST_EMIT))
    else $error("non-final result outside a drain");

  // Fill count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((count_r == $past(count_r)) ||
                      (count_r == $past(count_r) + 1'b1) ||
                      (count_r == $past(count_r) - 1'b1)))
    else $error("term count jumped");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_sparse_polynomial_term_adder_unit.sv -----
// Self-checking testbench for sparse_polynomial_term_adder_unit: directed and random
// add and drain traffic, checked against a built-in model of the sorted term table.
// Depends on spta_pkg and the RTL of the unit.
module tb_sparse_polynomial_term_adder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   TERM_SLOTS    = 16;
  localparam logic REQ_ADD       = 1'b0;
  localparam logic REQ_DRAIN     = 1'b1;
  localparam int   SETTLE_CYCLES = 6;
  localparam int   MAX_REPORTS   = 10;

  typedef struct packed {
    logic [spta_pkg::STAT_W-1:0] status;
    logic [spta_pkg::COEF_W-1:0] coef;
    logic [spta_pkg::EXPO_W-1:0] expo;
    logic                        sat;
    logic                        last;
    logic [4:0]                  count;
  } term_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [23:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tready  = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;
  wire  [3:0]  out_tuser;
  wire         out_tlast;

  // Model of the term table and of the zero-removal flag
  logic signed [spta_pkg::COEF_W-1:0] poly_coef [TERM_SLOTS];
  logic        [spta_pkg::EXPO_W-1:0] poly_expo [TERM_SLOTS];
  int                                 held_terms       = 0;
  logic                               drop_zero_sums_q = 1'b1;

  term_result_t pending_terms [$];
  int errors        = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int status_seen [8];
  int send_idle_pct = 35;
  int recv_idle_pct = 70;

  always #4 clk = ~clk;

  sparse_polynomial_term_adder_unit #(
    .TERM_SLOTS (TERM_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  function automatic void expect_term(input logic [spta_pkg::STAT_W-1:0] st,
                                      input logic [spta_pkg::COEF_W-1:0] c,
                                      input logic [spta_pkg::EXPO_W-1:0] e, input logic sat,
                                      input logic last, input int cnt);
    term_result_t r;
    r.status = st;
    r.coef   = c;
    r.expo   = e;
    r.sat    = sat;
    r.last   = last;
    r.count  = cnt[4:0];
    pending_terms.push_back(r);
  endfunction

  // Apply one accepted request to the table model and queue what it must produce
  function automatic void predict_request(input logic req,
                                          input logic [spta_pkg::COEF_W-1:0] c,
                                          input logic [spta_pkg::EXPO_W-1:0] e);
    int   slot;
    int   sum;
    int   i;
    logic sat;
    if (req == REQ_DRAIN) begin
      if (held_terms == 0) expect_term(spta_pkg::ST_EMPTY, '0, '0, 1'b0, 1'b1, 0);
      for (i = 0; i < held_terms; i++)
        expect_term(spta_pkg::ST_EMIT, poly_coef[i], poly_expo[i], 1'b0,
                    i == held_terms - 1, 0);
      held_terms = 0;
    end else begin
      slot = 0;
      while (slot < held_terms && poly_expo[slot] > e) slot++;
      if (slot < held_terms && poly_expo[slot] == e) begin
        sum = int'(poly_coef[slot]) + int'($signed(c));
        sat = 1'b0;
        if (sum > 32767) begin
          sum = 32767;
          sat = 1'b1;
        end else if (sum < -32768) begin
          sum = -32768;
          sat = 1'b1;
        end
        if (sum == 0 && drop_zero_sums_q) begin
          // close the gap: terms below move up one slot
          for (i = slot; i < held_terms - 1; i++) begin
            poly_coef[i] = poly_coef[i + 1];
            poly_expo[i] = poly_expo[i + 1];
          end
          held_terms--;
          expect_term(spta_pkg::ST_ZERO_REMOVED, '0, e, sat, 1'b1, held_terms);
        end else begin
          poly_coef[slot] = sum[15:0];
          expect_term(spta_pkg::ST_COMBINE, sum[15:0], e, sat, 1'b1, held_terms);
        end
      end else if (held_terms >= TERM_SLOTS) begin
        expect_term(spta_pkg::ST_FULL, c, e, 1'b0, 1'b1, held_terms);
      end else begin
        // open a slot at the sorted position
        for (i = held_terms; i > slot; i--) begin
          poly_coef[i] = poly_coef[i - 1];
          poly_expo[i] = poly_expo[i - 1];
        end
        poly_coef[slot] = c;
        poly_expo[slot] = e;
        held_terms++;
        expect_term(spta_pkg::ST_INSERT, c, e, 1'b0, 1'b1, held_terms);
      end
    end
  endfunction

  // Coefficient for a random add: extremes, zero, exact cancellation or anything
  function automatic logic [spta_pkg::COEF_W-1:0] pick_coef(
      input logic [spta_pkg::EXPO_W-1:0] e);
    logic [spta_pkg::COEF_W-1:0] c;
    int                          roll;
    int                          i;
    roll = $urandom_range(99);
    c    = 16'($urandom);
    if (roll < 5) c = 16'h7FFF;
    else if (roll < 10) c = 16'h8000;
    else if (roll < 13) c = '0;
    else if (roll < 35)
      for (i = 0; i < held_terms; i++)
        if (poly_expo[i] == e) c = -poly_coef[i];
    return c;
  endfunction

  // Send one request; valid stays high after the transaction unless a gap follows
  task automatic send_req(input logic req, input logic [spta_pkg::COEF_W-1:0] c,
                          input logic [spta_pkg::EXPO_W-1:0] e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {e, c};
    do @(posedge clk); while (!in_tready);
    predict_request(req, c, e);
    requests_sent++;
  endtask

  // Hold off input until every expected result has arrived
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_drop_zero(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en        <= 1'b0;
    drop_zero_sums_q = value;
  endtask

  task automatic test_directed_cases();
    send_req(REQ_DRAIN, 16'h0000, 8'h00);   // empty readout right after reset
    send_req(REQ_ADD,   16'h7FFF, 8'hFF);
    send_req(REQ_ADD,   16'h8000, 8'h00);
    send_req(REQ_ADD,   16'h0000, 8'h64);   // zero coefficient is stored as is
    send_req(REQ_ADD,   16'h0001, 8'hFF);   // clamp at the top
    send_req(REQ_ADD,   16'hFFFF, 8'h00);   // clamp at the bottom
    send_req(REQ_ADD,   16'h0000, 8'h64);   // zero plus zero is removed
    send_req(REQ_ADD,   16'd1234, 8'h32);
    send_req(REQ_ADD,   16'hFB2E, 8'h32);   // cancels the term above
    send_req(REQ_ADD,   16'hFFFB, 8'h07);
    send_req(REQ_ADD,   16'h0003, 8'h07);   // plain combine
    send_req(REQ_DRAIN, 16'hFFFF, 8'hFF);   // term data ignored on drain
    send_req(REQ_DRAIN, 16'h5A5A, 8'hA5);   // table was cleared by the drain
    settle();
  endtask

  task automatic test_keep_zero_sums();
    write_drop_zero(1'b0);
    send_req(REQ_ADD,   16'd5,    8'h09);
    send_req(REQ_ADD,   16'hFFFB, 8'h09);   // sum zero, term kept
    send_req(REQ_ADD,   16'h0000, 8'h09);   // combine into a zero term
    send_req(REQ_ADD,   16'h8000, 8'h80);
    send_req(REQ_ADD,   16'h8000, 8'h80);   // clamp with removal off
    send_req(REQ_DRAIN, 16'h0000, 8'h00);
    settle();
    write_drop_zero(1'b1);
  endtask

  task automatic test_full_table();
    int                          i;
    logic                        found;
    logic [spta_pkg::EXPO_W-1:0] e;
    // disjoint exponent windows give distinct terms
    for (i = 0; i < TERM_SLOTS; i++)
      send_req(REQ_ADD, 16'($urandom_range(1, 1000)), 8'(i * 16 + $urandom_range(15)));
    found = 1'b1;
    while (found) begin
      e     = 8'($urandom);
      found = 1'b0;
      for (i = 0; i < held_terms; i++)
        if (poly_expo[i] == e) found = 1'b1;
    end
    send_req(REQ_ADD, 16'($urandom), e);                 // dropped, table full
    send_req(REQ_ADD, 16'd1, poly_expo[3]);              // combine still works when full
    send_req(REQ_ADD, -poly_coef[5], poly_expo[5]);      // removal frees a slot
    send_req(REQ_ADD, 16'($urandom), e);                 // now it fits
    send_req(REQ_DRAIN, 16'($urandom), 8'($urandom));
    settle();
  endtask

  // Mostly well-formed polynomials in a narrow exponent window, then a drain;
  // some sequences are left undrained and some requests are stray noise
  task automatic run_random_phase(input int n_items, input int s_idle, input int r_idle,
                                  input logic drop);
    int                          sent;
    int                          len;
    int                          span;
    int                          base;
    logic [spta_pkg::EXPO_W-1:0] e;
    settle();
    write_drop_zero(drop);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(24) == 0) settle();
      if ($urandom_range(7) == 0) begin
        send_req(1'($urandom_range(1)), 16'($urandom), 8'($urandom));
        sent++;
      end else begin
        len  = ($urandom_range(4) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 10);
        span = $urandom_range(1, 48);
        base = $urandom_range(0, 255 - span);
        repeat (len) begin
          e = 8'(base + $urandom_range(0, span));
          send_req(REQ_ADD, pick_coef(e), e);
          sent++;
        end
        if ($urandom_range(4) != 0) begin
          send_req(REQ_DRAIN, 16'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Compare each result transaction with the oldest expectation; randomize ready
  always @(posedge clk) begin
    term_result_t got;
    term_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[2:0];
      got.coef   = out_tdata[15:0];
      got.expo   = out_tdata[23:16];
      got.sat    = out_tuser[3];
      got.last   = out_tlast;
      got.count  = out_tdata[28:24];
      results_seen++;
      status_seen[got.status]++;
      if (pending_terms.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d coef %0d expo %0d",
                               got.status, $signed(got.coef), got.expo));
      end else begin
        want = pending_terms.pop_front();
        if (got !== want)
          note_failure({$sformatf("expected status %0d coef %0d expo %0d sat %b last %b ",
                                  want.status, $signed(want.coef), want.expo, want.sat,
                                  want.last),
                        $sformatf("count %0d, got status %0d coef %0d expo %0d sat %b ",
                                  want.count, got.status, $signed(got.coef), got.expo,
                                  got.sat),
                        $sformatf("last %b count %0d", got.last, got.count)});
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_keep_zero_sums();
    test_full_table();
    run_random_phase(100, 35, 70, 1'b1);
    run_random_phase(100, 70, 35, 1'b0);
    run_random_phase(100, 0, 0, 1'b1);
    settle();
    $display("Covered %0d requests, %0d results: %0d inserts, %0d combines, %0d removals,",
             requests_sent, results_seen, status_seen[spta_pkg::ST_INSERT],
             status_seen[spta_pkg::ST_COMBINE], status_seen[spta_pkg::ST_ZERO_REMOVED]);
    $display("%0d full drops, %0d drained terms, %0d empty readouts, zero removal on and off",
             status_seen[spta_pkg::ST_FULL], status_seen[spta_pkg::ST_EMIT],
             status_seen[spta_pkg::ST_EMPTY]);
    if (errors == 0 && pending_terms.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_terms.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
